/* rtl/csc_pkg.sv */
// ============================================================================
// csc_pkg: shared types and constants for the speed and cadence decoder
// Widths of the arithmetic path, scaling constants, the packet record handed
// from the byte parser to the sequencer, and the sequencer state type.
// ============================================================================
package csc_pkg;

  // Wheel circumference register.
  localparam int CIRC_W = 12;
  localparam logic [CIRC_W-1:0] CIRC_RESET = 12'd2095;

  // Shared multiplier: 32-bit operand times a 12-bit operand.
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 12;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Scaling: speed = revs*circ*9*4096 / (dt*100), cadence = revs*1500*4096 / dt.
  localparam int                 SCALE_SHIFT = 12;
  localparam logic [MUL_B_W-1:0] SPEED_DEN_K = 12'd100;
  localparam logic [MUL_B_W-1:0] CADENCE_K   = 12'd1500;

  // Divider: dividend, divisor and saturated quotient widths.
  localparam int NINE_W    = PROD_W + 4;
  localparam int NUM_W     = NINE_W + SCALE_SHIFT;
  localparam int DEN_W     = 23;
  localparam int Q_W       = 16;
  localparam int HI_W      = NUM_W - Q_W;
  localparam int DIV_CNT_W = 5;
  localparam logic [Q_W-1:0] Q_SAT = 16'hFFFF;

  // Byte position counter saturates here.
  localparam logic [3:0] POS_MAX = 4'd15;

  // Fields of the packet being received, as seen after its last byte.
  typedef struct packed {
    logic [1:0]  flags;
    logic [31:0] wheel_revs;
    logic [15:0] wheel_time;
    logic [15:0] crank_revs;
    logic [15:0] crank_time;
  } csc_pkt_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_W_START,
    ST_W_MUL,
    ST_W_NUM,
    ST_W_DIVGO,
    ST_W_DIVWAIT,
    ST_C_START,
    ST_C_MUL,
    ST_C_DIVGO,
    ST_C_DIVWAIT,
    ST_FINISH
  } csc_state_t;

endpackage

/* rtl/csc_parser.sv */
// ============================================================================
// csc_parser: measurement packet byte parser
// Tracks the byte position, captures the flags byte and assembles the
// little-endian wheel and crank fields. Flags a packet that ends early.
// ============================================================================
module csc_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output csc_pkg::csc_pkt_t pkt,
  output logic              is_short
);

  logic [3:0]  pos_r, pos_nxt;
  logic [1:0]  flags_r, flags_nxt;
  logic [31:0] fa_r, fa_nxt;
  logic [31:0] wrevs_r, wrevs_nxt;
  logic [15:0] wtime_r, wtime_nxt;
  logic [15:0] crevs_r, crevs_nxt;
  logic [15:0] ctime_r, ctime_nxt;

  logic [3:0]  base;
  logic [3:0]  k_w;
  logic [3:0]  k_c;
  logic        wheel_hit;
  logic        crank_hit;
  logic [1:0]  lane;
  logic [31:0] asm_val;
  logic [1:0]  flags_eff;
  logic [3:0]  need;

  always_comb begin
    base      = flags_r[0] ? 4'd7 : 4'd1;
    k_w       = pos_r - 4'd1;
    k_c       = pos_r - base;
    wheel_hit = flags_r[0] && (pos_r >= 4'd1) && (pos_r <= 4'd6);
    crank_hit = !wheel_hit && flags_r[1] && (pos_r >= base) && (pos_r <= base + 4'd3);
    // Wheel bytes 4 and 5 of the field restart at lane 0 for the time word.
    lane      = wheel_hit ? k_w[1:0] : {1'b0, k_c[0]};
    if (lane == 2'd0) begin
      asm_val = {24'd0, data_byte};
    end else begin
      asm_val = fa_r | ({24'd0, data_byte} << {lane, 3'b000});
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    flags_nxt = flags_r;
    fa_nxt    = fa_r;
    wrevs_nxt = wrevs_r;
    wtime_nxt = wtime_r;
    crevs_nxt = crevs_r;
    ctime_nxt = ctime_r;
    if (take) begin
      if (pos_r == 4'd0) begin
        flags_nxt = data_byte[1:0];
        fa_nxt    = 32'd0;
      end else if (wheel_hit) begin
        fa_nxt = asm_val;
        if (k_w == 4'd3) wrevs_nxt = asm_val;
        if (k_w == 4'd5) wtime_nxt = asm_val[15:0];
      end else if (crank_hit) begin
        fa_nxt = asm_val;
        if (k_c == 4'd1) crevs_nxt = asm_val[15:0];
        if (k_c == 4'd3) ctime_nxt = asm_val[15:0];
      end
      if (last_byte) begin
        pos_nxt = 4'd0;
      end else if (pos_r < csc_pkg::POS_MAX) begin
        pos_nxt = pos_r + 4'd1;
      end
    end
  end

  // Packet length check uses the flags of the packet this byte belongs to.
  always_comb begin
    flags_eff = (pos_r == 4'd0) ? data_byte[1:0] : flags_r;
    need      = 4'd1 + (flags_eff[0] ? 4'd6 : 4'd0) + (flags_eff[1] ? 4'd4 : 4'd0);
    is_short  = ({1'b0, pos_r} + 5'd1) < {1'b0, need};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 4'd0;
      flags_r <= 2'd0;
      fa_r    <= 32'd0;
      wrevs_r <= 32'd0;
      wtime_r <= 16'd0;
      crevs_r <= 16'd0;
      ctime_r <= 16'd0;
    end else begin
      pos_r   <= pos_nxt;
      flags_r <= flags_nxt;
      fa_r    <= fa_nxt;
      wrevs_r <= wrevs_nxt;
      wtime_r <= wtime_nxt;
      crevs_r <= crevs_nxt;
      ctime_r <= ctime_nxt;
    end
  end

  assign pkt.flags      = flags_r;
  assign pkt.wheel_revs = wrevs_r;
  assign pkt.wheel_time = wtime_r;
  assign pkt.crank_revs = crevs_r;
  assign pkt.crank_time = ctime_r;

endmodule

/* rtl/csc_divider.sv */
// ============================================================================
// csc_divider: saturating restoring divider
// Divides a wide dividend by a nonzero divisor, one quotient bit per cycle.
// Quotients of 2^16 and above are detected up front and return all ones.
// ============================================================================
module csc_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [csc_pkg::NUM_W-1:0] num,
  input  logic [csc_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [csc_pkg::Q_W-1:0]   quot
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [csc_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [csc_pkg::DEN_W-1:0]     rem_r, rem_nxt;
  logic [csc_pkg::DEN_W-1:0]     den_r, den_nxt;
  logic [csc_pkg::Q_W-1:0]       low_r, low_nxt;
  logic [csc_pkg::Q_W-1:0]       q_r, q_nxt;

  logic [csc_pkg::HI_W-1:0]      hi;
  logic                          overflow;
  logic [csc_pkg::DEN_W:0]       trial;
  logic [csc_pkg::DEN_W:0]       diff;
  logic                          fits;

  always_comb begin
    hi       = num[csc_pkg::NUM_W-1:csc_pkg::Q_W];
    overflow = hi >= csc_pkg::HI_W'(den);
    trial    = {rem_r, low_r[csc_pkg::Q_W-1]};
    diff     = trial - {1'b0, den_r};
    fits     = trial >= {1'b0, den_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    low_nxt  = low_r;
    q_nxt    = q_r;
    if (start) begin
      den_nxt = den;
      if (overflow) begin
        q_nxt    = csc_pkg::Q_SAT;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = hi[csc_pkg::DEN_W-1:0];
        low_nxt  = num[csc_pkg::Q_W-1:0];
        q_nxt    = '0;
        cnt_nxt  = csc_pkg::DIV_CNT_W'(csc_pkg::Q_W);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = fits ? diff[csc_pkg::DEN_W-1:0] : trial[csc_pkg::DEN_W-1:0];
      low_nxt = {low_r[csc_pkg::Q_W-2:0], 1'b0};
      q_nxt   = {q_r[csc_pkg::Q_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == csc_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    low_r <= low_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

/* rtl/csc_measurement_speed_cadence.sv */
// ============================================================================
// csc_measurement_speed_cadence: cycling speed and cadence measurement decoder
// Decodes measurement packets byte by byte and reports speed and cadence.
// ============================================================================
// The block takes one packet byte per input transfer, flags byte first, with
// tlast on the final byte. Flags bit 0 announces a wheel field (32-bit
// revolutions, 16-bit event time in 1/1024 s) and bit 1 a crank field
// (16-bit revolutions, 16-bit event time), all little-endian. When the final
// byte arrives, speed in 0.01 km/h and cadence in 0.01 rpm are worked out from
// the differences to the previous event, both saturated at 65535. A result
// transfer follows when a present field had a nonzero previous event time, or
// when the packet was too short, in which case short_packet is set and the
// stored state is left alone. Bytes that are not last are taken back to back. A
// last byte holds the input off while the sequencer runs each present field
// that has a nonzero previous event time and a nonzero time step through one
// shared 32x12 multiplier and then one restoring divider that produces a
// quotient bit per cycle; the input is held off until that work is done and,
// when a result transfer follows, until the result has been placed in the output
// register, which waits while an earlier result is still held there.
// The circumference register may be written at any time; it is meant to
// change only while no packet is being finished.
module csc_measurement_speed_cadence (
  input  logic        clk,
  input  logic        rst_n,
  // Byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  // Results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] speed_centi_kmh, [31:16] cadence_centi_rpm
  output logic [2:0]  out_tuser,  // [0] speed_valid, [1] cadence_valid, [2] short_packet
  // Wheel circumference in mm
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data
);

  localparam int NUM_W   = csc_pkg::NUM_W;
  localparam int DEN_W   = csc_pkg::DEN_W;
  localparam int PROD_W  = csc_pkg::PROD_W;
  localparam int NINE_W  = csc_pkg::NINE_W;
  localparam int SH      = csc_pkg::SCALE_SHIFT;

  csc_pkg::csc_state_t state_r, state_nxt;

  logic                        in_take;
  csc_pkg::csc_pkt_t           pkt;
  logic                        pkt_short;

  logic [csc_pkg::CIRC_W-1:0]  circ_r, circ_nxt;

  // Previous events and reported values.
  logic [31:0] prev_wrevs_r, prev_wrevs_nxt;
  logic [15:0] prev_wtime_r, prev_wtime_nxt;
  logic [15:0] prev_crevs_r, prev_crevs_nxt;
  logic [15:0] prev_ctime_r, prev_ctime_nxt;
  logic [15:0] speed_r, speed_nxt;
  logic [15:0] cadence_r, cadence_nxt;
  logic        speed_seen_r, speed_seen_nxt;
  logic        cadence_seen_r, cadence_seen_nxt;
  logic        emit_r, emit_nxt;
  logic        short_r, short_nxt;

  // Arithmetic working registers.
  logic [31:0]        drevs_r, drevs_nxt;
  logic [15:0]        dt_r, dt_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [DEN_W-1:0]   den_r, den_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;
  logic [2:0]  out_user_r, out_user_nxt;

  // Shared multiplier.
  logic [csc_pkg::MUL_A_W-1:0] mul_a;
  logic [csc_pkg::MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]           mul_p;
  logic [NINE_W-1:0]           nine;

  logic                        div_start;
  logic                        div_done;
  logic [csc_pkg::Q_W-1:0]     div_q;

  logic [15:0] wheel_dt;
  logic [15:0] crank_dt;

  assign in_tready = (state_r == csc_pkg::ST_IDLE);
  assign in_take   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  csc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_take),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .pkt       (pkt),
    .is_short  (pkt_short)
  );

  csc_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_q)
  );

  always_comb begin
    mul_a = drevs_r;
    mul_b = circ_r;
    unique case (state_r)
      csc_pkg::ST_W_NUM: begin
        mul_a = {16'd0, dt_r};
        mul_b = csc_pkg::SPEED_DEN_K;
      end
      csc_pkg::ST_C_MUL: begin
        mul_b = csc_pkg::CADENCE_K;
      end
      default: begin
      end
    endcase
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    // Times nine, the remaining factor of 36864 after the 4096 shift.
    nine  = NINE_W'(prod_r) + {1'b0, prod_r, 3'b000};
  end

  assign wheel_dt = pkt.wheel_time - prev_wtime_r;
  assign crank_dt = pkt.crank_time - prev_ctime_r;

  always_comb begin
    state_nxt        = state_r;
    circ_nxt         = circ_r;
    prev_wrevs_nxt   = prev_wrevs_r;
    prev_wtime_nxt   = prev_wtime_r;
    prev_crevs_nxt   = prev_crevs_r;
    prev_ctime_nxt   = prev_ctime_r;
    speed_nxt        = speed_r;
    cadence_nxt      = cadence_r;
    speed_seen_nxt   = speed_seen_r;
    cadence_seen_nxt = cadence_seen_r;
    emit_nxt         = emit_r;
    short_nxt        = short_r;
    drevs_nxt        = drevs_r;
    dt_nxt           = dt_r;
    prod_nxt         = prod_r;
    num_nxt          = num_r;
    den_nxt          = den_r;
    out_valid_nxt    = out_valid_r;
    out_data_nxt     = out_data_r;
    out_user_nxt     = out_user_r;
    div_start        = 1'b0;

    if (cfg_valid && cfg_ready) begin
      circ_nxt = cfg_data;
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      csc_pkg::ST_IDLE: begin
        if (in_take && in_tlast) begin
          if (pkt_short) begin
            emit_nxt  = 1'b1;
            short_nxt = 1'b1;
            state_nxt = csc_pkg::ST_FINISH;
          end else begin
            emit_nxt  = 1'b0;
            short_nxt = 1'b0;
            state_nxt = csc_pkg::ST_W_START;
          end
        end
      end

      csc_pkg::ST_W_START: begin
        state_nxt = csc_pkg::ST_C_START;
        if (pkt.flags[0]) begin
          drevs_nxt      = pkt.wheel_revs - prev_wrevs_r;
          dt_nxt         = wheel_dt;
          prev_wrevs_nxt = pkt.wheel_revs;
          prev_wtime_nxt = pkt.wheel_time;
          if (prev_wtime_r != 16'd0) begin
            emit_nxt = 1'b1;
            // A zero time step keeps the previous speed.
            if (wheel_dt != 16'd0) state_nxt = csc_pkg::ST_W_MUL;
          end
        end
      end

      csc_pkg::ST_W_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = csc_pkg::ST_W_NUM;
      end

      csc_pkg::ST_W_NUM: begin
        num_nxt   = {nine, SH'(0)};
        den_nxt   = mul_p[DEN_W-1:0];
        state_nxt = csc_pkg::ST_W_DIVGO;
      end

      csc_pkg::ST_W_DIVGO: begin
        div_start = 1'b1;
        state_nxt = csc_pkg::ST_W_DIVWAIT;
      end

      csc_pkg::ST_W_DIVWAIT: begin
        if (div_done) begin
          speed_nxt      = div_q;
          speed_seen_nxt = 1'b1;
          state_nxt      = csc_pkg::ST_C_START;
        end
      end

      csc_pkg::ST_C_START: begin
        state_nxt = csc_pkg::ST_FINISH;
        if (pkt.flags[1]) begin
          drevs_nxt      = {16'd0, pkt.crank_revs - prev_crevs_r};
          dt_nxt         = crank_dt;
          prev_crevs_nxt = pkt.crank_revs;
          prev_ctime_nxt = pkt.crank_time;
          if (prev_ctime_r != 16'd0) begin
            emit_nxt = 1'b1;
            if (crank_dt != 16'd0) state_nxt = csc_pkg::ST_C_MUL;
          end
        end
      end

      csc_pkg::ST_C_MUL: begin
        num_nxt   = {(NUM_W - PROD_W - SH)'(0), mul_p, SH'(0)};
        den_nxt   = {(DEN_W - 16)'(0), dt_r};
        state_nxt = csc_pkg::ST_C_DIVGO;
      end

      csc_pkg::ST_C_DIVGO: begin
        div_start = 1'b1;
        state_nxt = csc_pkg::ST_C_DIVWAIT;
      end

      csc_pkg::ST_C_DIVWAIT: begin
        if (div_done) begin
          cadence_nxt      = div_q;
          cadence_seen_nxt = 1'b1;
          state_nxt        = csc_pkg::ST_FINISH;
        end
      end

      csc_pkg::ST_FINISH: begin
        if (!emit_r) begin
          state_nxt = csc_pkg::ST_IDLE;
        end else if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {cadence_r, speed_r};
          out_user_nxt  = {short_r, cadence_seen_r, speed_seen_r};
          state_nxt     = csc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = csc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      circ_r         <= csc_pkg::CIRC_RESET;
      prev_wrevs_r   <= 32'd0;
      prev_wtime_r   <= 16'd0;
      prev_crevs_r   <= 16'd0;
      prev_ctime_r   <= 16'd0;
      speed_r        <= 16'd0;
      cadence_r      <= 16'd0;
      speed_seen_r   <= 1'b0;
      cadence_seen_r <= 1'b0;
      emit_r         <= 1'b0;
      short_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      circ_r         <= circ_nxt;
      prev_wrevs_r   <= prev_wrevs_nxt;
      prev_wtime_r   <= prev_wtime_nxt;
      prev_crevs_r   <= prev_crevs_nxt;
      prev_ctime_r   <= prev_ctime_nxt;
      speed_r        <= speed_nxt;
      cadence_r      <= cadence_nxt;
      speed_seen_r   <= speed_seen_nxt;
      cadence_seen_r <= cadence_seen_nxt;
      emit_r         <= emit_nxt;
      short_r        <= short_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    drevs_r    <= drevs_nxt;
    dt_r       <= dt_nxt;
    prod_r     <= prod_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
